[design/assert_macros.svh]
// ============================================================================
// Assertion macros
// Shared concurrent assertion forms, clocked on clk and disabled in reset.
// ============================================================================
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition that must hold at every clock edge out of reset.
`define ASSERT_ALWAYS(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// Antecedent in one cycle implies the consequent in the next cycle.
`define ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[design/ensc_pkg.sv]
// ============================================================================
// ensc_pkg
// Types, constants and arithmetic helpers shared by the compensation pipeline.
// ============================================================================
package ensc_pkg;

    localparam int unsigned DivSteps = 32;

    localparam logic [2:0] RegTemp   = 3'd0;
    localparam logic [2:0] RegPressA = 3'd1;
    localparam logic [2:0] RegPressB = 3'd2;
    localparam logic [2:0] RegPressC = 3'd3;
    localparam logic [2:0] RegHum    = 3'd4;

    localparam logic [31:0] HumMax = 32'd419430400;

    typedef struct packed {
        logic [19:0] raw_temp;
        logic [19:0] raw_press;
        logic [15:0] raw_hum;
    } sample_t;

    typedef struct packed {
        logic signed [31:0] fine_temp;
        logic signed [31:0] temp_centi;
        logic [31:0]        press_pa;
        logic [16:0]        hum_q10;
        logic               press_invalid;
    } result_t;

    // Calibration words, each already extended to 32 bits.
    typedef struct packed {
        logic [31:0] t1, t2, t3;
        logic [31:0] p1, p2, p3, p4, p5, p6, p7, p8, p9;
        logic [31:0] h1, h2, h3, h4, h5, h6;
    } cal_t;

    // Front end to divider.
    typedef struct packed {
        logic [31:0] fine_temp;
        logic [31:0] temp_centi;
        logic [31:0] num;
        logic [31:0] den;
        logic [31:0] hum_x;
        logic [31:0] hum_w;
    } front_t;

    // Side payload carried through the divider.
    typedef struct packed {
        logic [31:0] fine_temp;
        logic [31:0] temp_centi;
        logic [31:0] hum_x;
        logic [31:0] hum_w;
        logic        dbl;
        logic        bad;
    } div_side_t;

    // Divider to back end.
    typedef struct packed {
        div_side_t   side;
        logic [31:0] quo;
    } div_res_t;

    function automatic logic [31:0] mul32(input logic [31:0] a, input logic [31:0] b);
        logic [63:0] pr;
        pr = a * b;
        return pr[31:0];
    endfunction

    function automatic logic [31:0] asr(input logic [31:0] x, input int unsigned n);
        return $signed(x) >>> n;
    endfunction

endpackage

[design/ensc_front.sv]
// ============================================================================
// ensc_front
// Eight-stage pipeline: temperature, pressure operands and humidity factors.
// ============================================================================
module ensc_front
(
    input  logic              clk,
    input  logic              rst_n,
    input  ensc_pkg::cal_t    cal,
    input  logic              in_valid,
    output logic              in_ready,
    input  ensc_pkg::sample_t in_data,
    output logic              out_valid,
    input  logic              out_ready,
    output ensc_pkg::front_t  out_data
);

    localparam int Stages = 8;

    logic [Stages-1:0] v_reg;
    logic [Stages-1:0] vin;
    logic [Stages:0]   rdy;
    logic [Stages-1:0] ld;

    always_comb
    begin
        rdy[Stages] = out_ready;
        for (int k = Stages - 1; k >= 0; k--)
        begin
            rdy[k] = !v_reg[k] || rdy[k+1];
        end
    end

    assign vin       = {v_reg[Stages-2:0], in_valid};
    assign ld        = rdy[Stages-1:0] & vin;
    assign in_ready  = rdy[0];
    assign out_valid = v_reg[Stages-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else
        begin
            for (int k = 0; k < Stages; k++)
            begin
                if (rdy[k])
                begin
                    v_reg[k] <= vin[k];
                end
            end
        end
    end

    logic [31:0] rt, rp, rh, d0;
    assign rt = {12'd0, in_data.raw_temp};
    assign rp = {12'd0, in_data.raw_press};
    assign rh = {16'd0, in_data.raw_hum};
    assign d0 = (rt >> 4) - cal.t1;

    // Stage 1
    logic [31:0] s1_m1_reg, s1_dd_reg, s1_rp_reg, s1_rh_reg;
    always_ff @(posedge clk)
    begin
        if (ld[0])
        begin
            s1_m1_reg <= ensc_pkg::mul32((rt >> 3) - (cal.t1 << 1), cal.t2);
            s1_dd_reg <= ensc_pkg::mul32(d0, d0);
            s1_rp_reg <= rp;
            s1_rh_reg <= rh;
        end
    end

    // Stage 2
    logic [31:0] s2_a_reg, s2_m2_reg, s2_rp_reg, s2_rh_reg;
    always_ff @(posedge clk)
    begin
        if (ld[1])
        begin
            s2_a_reg  <= ensc_pkg::asr(s1_m1_reg, 11);
            s2_m2_reg <= ensc_pkg::mul32(ensc_pkg::asr(s1_dd_reg, 12), cal.t3);
            s2_rp_reg <= s1_rp_reg;
            s2_rh_reg <= s1_rh_reg;
        end
    end

    // Stage 3: fine temperature.
    logic [31:0] s3_tf_reg, s3_rp_reg, s3_rh_reg;
    always_ff @(posedge clk)
    begin
        if (ld[2])
        begin
            s3_tf_reg <= s2_a_reg + ensc_pkg::asr(s2_m2_reg, 14);
            s3_rp_reg <= s2_rp_reg;
            s3_rh_reg <= s2_rh_reg;
        end
    end

    // Stage 4
    logic [31:0] s4_tf_reg, s4_tc_reg, s4_pa_reg, s4_q_reg, s4_v_reg, s4_rp_reg, s4_rh_reg;
    logic [31:0] pa4;
    assign pa4 = ensc_pkg::asr(s3_tf_reg, 1) - 32'd64000;
    always_ff @(posedge clk)
    begin
        if (ld[3])
        begin
            s4_tf_reg <= s3_tf_reg;
            s4_tc_reg <= ensc_pkg::asr((s3_tf_reg << 2) + s3_tf_reg + 32'd128, 8);
            s4_pa_reg <= pa4;
            s4_q_reg  <= ensc_pkg::asr(pa4, 2);
            s4_v_reg  <= s3_tf_reg - 32'd76800;
            s4_rp_reg <= s3_rp_reg;
            s4_rh_reg <= s3_rh_reg;
        end
    end

    // Stage 5
    logic [31:0] s5_sq_reg, s5_ap5_reg, s5_p2a_reg, s5_hx_reg, s5_hy_reg, s5_hz_reg;
    logic [31:0] s5_tf_reg, s5_tc_reg, s5_rp_reg, s5_rh_reg;
    always_ff @(posedge clk)
    begin
        if (ld[4])
        begin
            s5_sq_reg  <= ensc_pkg::mul32(s4_q_reg, s4_q_reg);
            s5_ap5_reg <= ensc_pkg::mul32(s4_pa_reg, cal.p5);
            s5_p2a_reg <= ensc_pkg::mul32(cal.p2, s4_pa_reg);
            s5_hx_reg  <= ensc_pkg::mul32(cal.h5, s4_v_reg);
            s5_hy_reg  <= ensc_pkg::mul32(s4_v_reg, cal.h6);
            s5_hz_reg  <= ensc_pkg::mul32(s4_v_reg, cal.h3);
            s5_tf_reg  <= s4_tf_reg;
            s5_tc_reg  <= s4_tc_reg;
            s5_rp_reg  <= s4_rp_reg;
            s5_rh_reg  <= s4_rh_reg;
        end
    end

    // Stage 6
    logic [31:0] s6_b0_reg, s6_p3m_reg, s6_x_reg, s6_yz_reg, s6_ap5_reg, s6_p2a_reg;
    logic [31:0] s6_tf_reg, s6_tc_reg, s6_rp_reg;
    always_ff @(posedge clk)
    begin
        if (ld[5])
        begin
            s6_b0_reg  <= ensc_pkg::mul32(ensc_pkg::asr(s5_sq_reg, 11), cal.p6);
            s6_p3m_reg <= ensc_pkg::mul32(cal.p3, ensc_pkg::asr(s5_sq_reg, 13));
            s6_x_reg   <= ensc_pkg::asr((s5_rh_reg << 14) - (cal.h4 << 20) - s5_hx_reg
                                        + 32'd16384, 15);
            s6_yz_reg  <= ensc_pkg::mul32(ensc_pkg::asr(s5_hy_reg, 10),
                                          ensc_pkg::asr(s5_hz_reg, 11) + 32'd32768);
            s6_ap5_reg <= s5_ap5_reg;
            s6_p2a_reg <= s5_p2a_reg;
            s6_tf_reg  <= s5_tf_reg;
            s6_tc_reg  <= s5_tc_reg;
            s6_rp_reg  <= s5_rp_reg;
        end
    end

    // Stage 7
    logic [31:0] s7_b_reg, s7_a2_reg, s7_hw_reg, s7_x_reg, s7_tf_reg, s7_tc_reg, s7_rp_reg;
    always_ff @(posedge clk)
    begin
        if (ld[6])
        begin
            s7_b_reg  <= ensc_pkg::asr(s6_b0_reg + (s6_ap5_reg << 1), 2) + (cal.p4 << 16);
            s7_a2_reg <= ensc_pkg::asr(ensc_pkg::asr(s6_p3m_reg, 3)
                                       + ensc_pkg::asr(s6_p2a_reg, 1), 18);
            s7_hw_reg <= ensc_pkg::mul32(ensc_pkg::asr(s6_yz_reg, 10) + 32'd2097152, cal.h2);
            s7_x_reg  <= s6_x_reg;
            s7_tf_reg <= s6_tf_reg;
            s7_tc_reg <= s6_tc_reg;
            s7_rp_reg <= s6_rp_reg;
        end
    end

    // Stage 8: divider operands.
    ensc_pkg::front_t s8_reg;
    always_ff @(posedge clk)
    begin
        if (ld[7])
        begin
            s8_reg.den        <= ensc_pkg::asr(ensc_pkg::mul32(32'd32768 + s7_a2_reg, cal.p1), 15);
            s8_reg.num        <= ensc_pkg::mul32((32'd1048576 - s7_rp_reg)
                                                 - ensc_pkg::asr(s7_b_reg, 12), 32'd3125);
            s8_reg.hum_w      <= ensc_pkg::asr(s7_hw_reg + 32'd8192, 14);
            s8_reg.hum_x      <= s7_x_reg;
            s8_reg.fine_temp  <= s7_tf_reg;
            s8_reg.temp_centi <= s7_tc_reg;
        end
    end

    assign out_data = s8_reg;

endmodule

[design/ensc_div.sv]
// ============================================================================
// ensc_div
// Pipelined restoring divider, one quotient bit per stage.
// ============================================================================
module ensc_div
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  ensc_pkg::front_t   in_data,
    output logic               out_valid,
    input  logic               out_ready,
    output ensc_pkg::div_res_t out_data
);

    localparam int Steps = ensc_pkg::DivSteps;

    logic [Steps-1:0]    v_reg;
    logic [Steps-1:0]    vin;
    logic [Steps:0]      rdy;
    logic [31:0]         rem_reg  [Steps];
    logic [31:0]         quo_reg  [Steps];
    logic [31:0]         den_reg  [Steps];
    ensc_pkg::div_side_t side_reg [Steps];

    always_comb
    begin
        rdy[Steps] = out_ready;
        for (int k = Steps - 1; k >= 0; k--)
        begin
            rdy[k] = !v_reg[k] || rdy[k+1];
        end
    end

    assign vin       = {v_reg[Steps-2:0], in_valid};
    assign in_ready  = rdy[0];
    assign out_valid = v_reg[Steps-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else
        begin
            for (int k = 0; k < Steps; k++)
            begin
                if (rdy[k])
                begin
                    v_reg[k] <= vin[k];
                end
            end
        end
    end

    // A dividend below 2^31 is doubled before the division; otherwise the
    // quotient is doubled afterwards.
    ensc_pkg::div_side_t side0;
    logic [31:0]         dividend0;
    always_comb
    begin
        side0.fine_temp  = in_data.fine_temp;
        side0.temp_centi = in_data.temp_centi;
        side0.hum_x      = in_data.hum_x;
        side0.hum_w      = in_data.hum_w;
        side0.dbl        = in_data.num[31];
        side0.bad        = (in_data.den == '0);
        dividend0        = in_data.num[31] ? in_data.num : {in_data.num[30:0], 1'b0};
    end

    for (genvar k = 0; k < Steps; k++)
    begin : g_step
        logic [31:0]         rem_in, quo_in, den_in;
        ensc_pkg::div_side_t side_in;
        logic [32:0]         trial;

        if (k == 0)
        begin : g_first
            assign rem_in  = '0;
            assign quo_in  = dividend0;
            assign den_in  = in_data.den;
            assign side_in = side0;
        end
        else
        begin : g_next
            assign rem_in  = rem_reg[k-1];
            assign quo_in  = quo_reg[k-1];
            assign den_in  = den_reg[k-1];
            assign side_in = side_reg[k-1];
        end

        assign trial = {rem_in, quo_in[31]} - {1'b0, den_in};

        always_ff @(posedge clk)
        begin
            if (rdy[k] && vin[k])
            begin
                if (!trial[32])
                begin
                    rem_reg[k] <= trial[31:0];
                    quo_reg[k] <= {quo_in[30:0], 1'b1};
                end
                else
                begin
                    rem_reg[k] <= {rem_in[30:0], quo_in[31]};
                    quo_reg[k] <= {quo_in[30:0], 1'b0};
                end
                den_reg[k]  <= den_in;
                side_reg[k] <= side_in;
            end
        end
    end

    assign out_data.side = side_reg[Steps-1];
    assign out_data.quo  = quo_reg[Steps-1];

endmodule

[design/ensc_post.sv]
// ============================================================================
// ensc_post
// Four-stage back end: pressure correction, humidity finish and clamp.
// ============================================================================
module ensc_post
(
    input  logic               clk,
    input  logic               rst_n,
    input  ensc_pkg::cal_t     cal,
    input  logic               in_valid,
    output logic               in_ready,
    input  ensc_pkg::div_res_t in_data,
    output logic               out_valid,
    input  logic               out_ready,
    output ensc_pkg::result_t  out_data
);

    localparam int Stages = 4;

    logic [Stages-1:0] v_reg;
    logic [Stages-1:0] vin;
    logic [Stages:0]   rdy;
    logic [Stages-1:0] ld;

    always_comb
    begin
        rdy[Stages] = out_ready;
        for (int k = Stages - 1; k >= 0; k--)
        begin
            rdy[k] = !v_reg[k] || rdy[k+1];
        end
    end

    assign vin       = {v_reg[Stages-2:0], in_valid};
    assign ld        = rdy[Stages-1:0] & vin;
    assign in_ready  = rdy[0];
    assign out_valid = v_reg[Stages-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else
        begin
            for (int k = 0; k < Stages; k++)
            begin
                if (rdy[k])
                begin
                    v_reg[k] <= vin[k];
                end
            end
        end
    end

    logic [31:0] p0;
    always_comb
    begin
        if (in_data.side.bad)
        begin
            p0 = '0;
        end
        else if (in_data.side.dbl)
        begin
            p0 = {in_data.quo[30:0], 1'b0};
        end
        else
        begin
            p0 = in_data.quo;
        end
    end

    // Stage 1
    logic [31:0] s1_p_reg, s1_pp_reg, s1_e0_reg, s1_hv_reg, s1_tf_reg, s1_tc_reg;
    logic        s1_bad_reg;
    always_ff @(posedge clk)
    begin
        if (ld[0])
        begin
            s1_p_reg   <= p0;
            s1_pp_reg  <= ensc_pkg::mul32(p0 >> 3, p0 >> 3);
            s1_e0_reg  <= ensc_pkg::mul32(p0 >> 2, cal.p8);
            s1_hv_reg  <= ensc_pkg::mul32(in_data.side.hum_x, in_data.side.hum_w);
            s1_tf_reg  <= in_data.side.fine_temp;
            s1_tc_reg  <= in_data.side.temp_centi;
            s1_bad_reg <= in_data.side.bad;
        end
    end

    // Stage 2
    logic [31:0] s2_p_reg, s2_c0_reg, s2_e0_reg, s2_hv_reg, s2_ss_reg, s2_tf_reg, s2_tc_reg;
    logic [31:0] s1_s;
    logic        s2_bad_reg;
    assign s1_s = ensc_pkg::asr(s1_hv_reg, 15);
    always_ff @(posedge clk)
    begin
        if (ld[1])
        begin
            s2_p_reg   <= s1_p_reg;
            s2_c0_reg  <= ensc_pkg::mul32(cal.p9, s1_pp_reg >> 13);
            s2_e0_reg  <= s1_e0_reg;
            s2_hv_reg  <= s1_hv_reg;
            s2_ss_reg  <= ensc_pkg::mul32(s1_s, s1_s);
            s2_tf_reg  <= s1_tf_reg;
            s2_tc_reg  <= s1_tc_reg;
            s2_bad_reg <= s1_bad_reg;
        end
    end

    // Stage 3
    logic [31:0] s3_p_reg, s3_hv_reg, s3_hsub_reg, s3_tf_reg, s3_tc_reg;
    logic        s3_bad_reg;
    always_ff @(posedge clk)
    begin
        if (ld[2])
        begin
            if (s2_bad_reg)
            begin
                s3_p_reg <= '0;
            end
            else
            begin
                s3_p_reg <= s2_p_reg + ensc_pkg::asr(ensc_pkg::asr(s2_c0_reg, 12)
                                                     + ensc_pkg::asr(s2_e0_reg, 13)
                                                     + cal.p7, 4);
            end
            s3_hv_reg   <= s2_hv_reg;
            s3_hsub_reg <= ensc_pkg::mul32(ensc_pkg::asr(s2_ss_reg, 7), cal.h1);
            s3_tf_reg   <= s2_tf_reg;
            s3_tc_reg   <= s2_tc_reg;
            s3_bad_reg  <= s2_bad_reg;
        end
    end

    // Stage 4: humidity clamp and result register.
    logic [31:0] hfin, hclamp;
    always_comb
    begin
        hfin = s3_hv_reg - ensc_pkg::asr(s3_hsub_reg, 4);
        if (hfin[31])
        begin
            hclamp = '0;
        end
        else if (hfin > ensc_pkg::HumMax)
        begin
            hclamp = ensc_pkg::HumMax;
        end
        else
        begin
            hclamp = hfin;
        end
    end

    ensc_pkg::result_t s4_reg;
    always_ff @(posedge clk)
    begin
        if (ld[3])
        begin
            s4_reg.fine_temp     <= s3_tf_reg;
            s4_reg.temp_centi    <= s3_tc_reg;
            s4_reg.press_pa      <= s3_p_reg;
            s4_reg.hum_q10       <= hclamp[28:12];
            s4_reg.press_invalid <= s3_bad_reg;
        end
    end

    assign out_data = s4_reg;

endmodule

[design/env_sensor_compensation_top.sv]
// ============================================================================
// env_sensor_compensation_top
// Integer compensation of temperature, pressure and humidity samples.
// ============================================================================
// Usage:
// A raw sample (temperature, pressure, humidity) enters on the in_* channel
// as one valid/ready transaction. One result transaction leaves on out_*:
// fine temperature, temperature in 0.01 C, pressure in Pa, humidity in
// percent times 1024, and a flag that marks a zero pressure divisor (the
// pressure then reads 0).
// Calibration words are written on the cfg_* channel, index 0 to 4; other
// indexes are ignored. cfg_ready is always high. Write them only while no
// sample is in flight.
// The path has 8 front stages, 32 divider stages (one quotient bit each),
// and 4 back stages. One sample is accepted per cycle while the receiver does not stall.
// Every stage carries a valid bit and loads whenever it is empty or the stage
// after it moves, so a stalled receiver fills bubbles first and only then
// stops the input. Nothing is dropped or repeated.
// Reset clears the valid bits and all calibration words to zero.
// ============================================================================
module env_sensor_compensation_top
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  ensc_pkg::sample_t in_data,
    output logic              out_valid,
    input  logic              out_ready,
    output ensc_pkg::result_t out_data,
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic [2:0]        cfg_index,
    input  logic [63:0]       cfg_data
);

    // Calibration register file.
    logic [47:0] temp_coeffs_reg;
    logic [47:0] press_a_reg;
    logic [47:0] press_b_reg;
    logic [47:0] press_c_reg;
    logic [63:0] hum_coeffs_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            temp_coeffs_reg <= '0;
            press_a_reg     <= '0;
            press_b_reg     <= '0;
            press_c_reg     <= '0;
            hum_coeffs_reg  <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                ensc_pkg::RegTemp:   temp_coeffs_reg <= cfg_data[47:0];
                ensc_pkg::RegPressA: press_a_reg     <= cfg_data[47:0];
                ensc_pkg::RegPressB: press_b_reg     <= cfg_data[47:0];
                ensc_pkg::RegPressC: press_c_reg     <= cfg_data[47:0];
                ensc_pkg::RegHum:    hum_coeffs_reg  <= cfg_data;
                default:             ;
            endcase
        end
    end

    // Unpack the calibration words into sign- or zero-extended operands.
    ensc_pkg::cal_t cal;
    always_comb
    begin
        cal.t1 = {16'd0, temp_coeffs_reg[15:0]};
        cal.t2 = {{16{temp_coeffs_reg[31]}}, temp_coeffs_reg[31:16]};
        cal.t3 = {{16{temp_coeffs_reg[47]}}, temp_coeffs_reg[47:32]};
        cal.p1 = {16'd0, press_a_reg[15:0]};
        cal.p2 = {{16{press_a_reg[31]}}, press_a_reg[31:16]};
        cal.p3 = {{16{press_a_reg[47]}}, press_a_reg[47:32]};
        cal.p4 = {{16{press_b_reg[15]}}, press_b_reg[15:0]};
        cal.p5 = {{16{press_b_reg[31]}}, press_b_reg[31:16]};
        cal.p6 = {{16{press_b_reg[47]}}, press_b_reg[47:32]};
        cal.p7 = {{16{press_c_reg[15]}}, press_c_reg[15:0]};
        cal.p8 = {{16{press_c_reg[31]}}, press_c_reg[31:16]};
        cal.p9 = {{16{press_c_reg[47]}}, press_c_reg[47:32]};
        cal.h1 = {24'd0, hum_coeffs_reg[7:0]};
        cal.h2 = {{16{hum_coeffs_reg[23]}}, hum_coeffs_reg[23:8]};
        cal.h3 = {24'd0, hum_coeffs_reg[31:24]};
        cal.h4 = {{20{hum_coeffs_reg[43]}}, hum_coeffs_reg[43:32]};
        cal.h5 = {{20{hum_coeffs_reg[55]}}, hum_coeffs_reg[55:44]};
        cal.h6 = {{24{hum_coeffs_reg[63]}}, hum_coeffs_reg[63:56]};
    end

    logic               front_valid, front_ready;
    ensc_pkg::front_t   front_data;
    logic               div_valid, div_ready;
    ensc_pkg::div_res_t div_data;

    ensc_front u_front
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cal       (cal),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (front_valid),
        .out_ready (front_ready),
        .out_data  (front_data)
    );

    ensc_div u_div
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (front_valid),
        .in_ready  (front_ready),
        .in_data   (front_data),
        .out_valid (div_valid),
        .out_ready (div_ready),
        .out_data  (div_data)
    );

    ensc_post u_post
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cal       (cal),
        .in_valid  (div_valid),
        .in_ready  (div_ready),
        .in_data   (div_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

endmodule

[design/ensc_checker.sv]
// ============================================================================
// ensc_checker
// Port-level checks on the result channel of the compensation block.
// ============================================================================
`include "assert_macros.svh"

module ensc_checker
(
    input logic              clk,
    input logic              rst_n,
    input logic              out_valid,
    input logic              out_ready,
    input ensc_pkg::result_t out_data
);

    // A stalled result transaction stays offered.
    `ASSERT_ALWAYS(a_out_hold, !($past(out_valid && !out_ready) && !out_valid), "result dropped while stalled")

    // A stalled result transaction keeps its payload.
    `ASSERT_ALWAYS(a_out_stable, !($past(out_valid && !out_ready)) || $stable(out_data), "result changed while stalled")

    // A zero divisor always reports zero pressure.
    `ASSERT_ALWAYS(a_bad_zero, !(out_valid && out_data.press_invalid) || (out_data.press_pa == '0), "invalid pressure not zero")

    // Humidity never exceeds 100 percent.
    `ASSERT_ALWAYS(a_hum_range, !out_valid || (out_data.hum_q10 <= 17'd102400), "humidity out of range")

endmodule

bind env_sensor_compensation_top ensc_checker u_chk
(
    .clk       (clk),
    .rst_n     (rst_n),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
);

[tb/tb_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the sensor compensation pipeline. A queue of raw
// samples feeds a clocked driver; a clocked monitor compares every result
// transaction with a prediction computed from the calibration in force.
// ----------------------------------------------------------------------------
module tb_top;

    logic                clk;
    logic                rst_n;
    logic                in_valid;
    logic                in_ready;
    ensc_pkg::sample_t   in_data;
    logic                out_valid;
    logic                out_ready;
    ensc_pkg::result_t   out_data;
    logic                cfg_valid;
    logic                cfg_ready;
    logic [2:0]          cfg_index;
    logic [63:0]         cfg_data;

    env_sensor_compensation_top i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // Pipeline depth given for the block; used for the settle pauses.
    localparam int PipeDepth = 44;

    // Register index that the block does not decode.
    localparam logic [2:0] RegUnused = 3'd7;

    // Calibration copy that the predictor reads.
    logic [63:0] cal_temp, cal_pa, cal_pb, cal_pc;
    logic [63:0] cal_hum;

    ensc_pkg::sample_t sample_queue[$];
    ensc_pkg::result_t expected_results[$];

    int unsigned send_idle_pct;
    int unsigned recv_idle_pct;
    int unsigned hold_off_cycles;
    int unsigned mismatch_count;
    int unsigned result_count;
    int unsigned invalid_count;
    int unsigned clamp_count;

    // Acceptance of the input is recorded at the rising edge so the driver
    // knows whether the sample on the bus has been taken.
    logic in_ready_seen;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic logic [31:0] sx(input logic [63:0] w, input int lsb, input int bits);
        logic [31:0] v;
        v = 32'(w >> lsb) & ((32'd1 << bits) - 32'd1);
        return (v ^ (32'd1 << (bits - 1))) - (32'd1 << (bits - 1));
    endfunction

    function automatic logic [31:0] zx(input logic [63:0] w, input int lsb, input int bits);
        return 32'(w >> lsb) & ((32'd1 << bits) - 32'd1);
    endfunction

    function automatic logic [31:0] sra(input logic [31:0] x, input int n);
        return $signed(x) >>> n;
    endfunction

    function automatic logic [31:0] m32(input logic [31:0] a, input logic [31:0] b);
        logic [63:0] pr;
        pr = {32'd0, a} * {32'd0, b};
        return pr[31:0];
    endfunction

    // Compensates one raw sample with the calibration currently held.
    function automatic ensc_pkg::result_t compensate(input ensc_pkg::sample_t s);
        logic [31:0] t1, t2, t3, p1, p2, p3, p4, p5, p6, p7, p8, p9;
        logic [31:0] h1, h2, h3, h4, h5, h6;
        logic [31:0] a, b, d, q, sq, tf, tc, p, c, e, v, x, y, z, w, hs;
        logic signed [31:0] hv;
        ensc_pkg::result_t r;
        t1 = zx(cal_temp, 0, 16);  t2 = sx(cal_temp, 16, 16); t3 = sx(cal_temp, 32, 16);
        p1 = zx(cal_pa, 0, 16);    p2 = sx(cal_pa, 16, 16);   p3 = sx(cal_pa, 32, 16);
        p4 = sx(cal_pb, 0, 16);    p5 = sx(cal_pb, 16, 16);   p6 = sx(cal_pb, 32, 16);
        p7 = sx(cal_pc, 0, 16);    p8 = sx(cal_pc, 16, 16);   p9 = sx(cal_pc, 32, 16);
        h1 = zx(cal_hum, 0, 8);    h2 = sx(cal_hum, 8, 16);   h3 = zx(cal_hum, 24, 8);
        h4 = sx(cal_hum, 32, 12);  h5 = sx(cal_hum, 44, 12);  h6 = sx(cal_hum, 56, 8);

        // Temperature.
        a  = sra(m32(({12'd0, s.raw_temp} >> 3) - (t1 << 1), t2), 11);
        d  = ({12'd0, s.raw_temp} >> 4) - t1;
        b  = sra(m32(sra(m32(d, d), 12), t3), 14);
        tf = a + b;
        tc = sra(m32(tf, 32'd5) + 32'd128, 8);

        // Pressure.
        a  = sra(tf, 1) - 32'd64000;
        q  = sra(a, 2);
        sq = m32(q, q);
        b  = m32(sra(sq, 11), p6);
        b  = b + (m32(a, p5) << 1);
        b  = sra(b, 2) + (p4 << 16);
        a  = sra(sra(m32(p3, sra(sq, 13)), 3) + sra(m32(p2, a), 1), 18);
        a  = sra(m32(32'd32768 + a, p1), 15);
        r.press_invalid = (a == 32'd0);
        if (r.press_invalid)
        begin
            p = 32'd0;
        end
        else
        begin
            p = m32((32'd1048576 - {12'd0, s.raw_press}) - sra(b, 12), 32'd3125);
            if (p < 32'h8000_0000)
                p = (p << 1) / a;
            else
                p = (p / a) * 32'd2;
            c = sra(m32(p9, m32(p >> 3, p >> 3) >> 13), 12);
            e = sra(m32(p >> 2, p8), 13);
            p = p + sra(c + e + p7, 4);
        end

        // Humidity.
        v  = tf - 32'd76800;
        x  = sra(({16'd0, s.raw_hum} << 14) - (h4 << 20) - m32(h5, v) + 32'd16384, 15);
        y  = sra(m32(v, h6), 10);
        z  = sra(m32(v, h3), 11) + 32'd32768;
        w  = sra(m32(sra(m32(y, z), 10) + 32'd2097152, h2) + 32'd8192, 14);
        v  = m32(x, w);
        hs = sra(v, 15);
        v  = v - sra(m32(sra(m32(hs, hs), 7), h1), 4);
        hv = v;
        if (hv < 0)
            hv = 0;
        if (hv > $signed(ensc_pkg::HumMax))
            hv = ensc_pkg::HumMax;

        r.fine_temp  = tf;
        r.temp_centi = tc;
        r.press_pa   = p;
        r.hum_q10    = 17'(32'(hv) >> 12);
        return r;
    endfunction

    // Driver: presents queued samples at the falling edge. Valid is only
    // dropped once the current transaction has gone through.
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (!in_valid || in_ready_seen)
            begin
                if (sample_queue.size() > 0 && $urandom_range(99) >= send_idle_pct)
                begin
                    in_data  <= sample_queue.pop_front();
                    in_valid <= 1'b1;
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
            out_ready <= (hold_off_cycles == 0) && ($urandom_range(99) >= recv_idle_pct);
        end
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_ready_seen <= 1'b0;
        else
            in_ready_seen <= in_valid && in_ready;
    end

    // Predict at acceptance time; the calibration never changes while a
    // sample is in flight.
    always @(posedge clk)
    begin
        if (rst_n && in_valid && in_ready)
            expected_results.push_back(compensate(in_data));
    end

    // Monitor: checks each result transaction against the oldest prediction.
    always @(posedge clk)
    begin
        ensc_pkg::result_t exp_r;
        if (rst_n && out_valid && out_ready)
        begin
            result_count++;
            if (expected_results.size() == 0)
            begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("Unexpected result transaction: %p", out_data);
            end
            else
            begin
                exp_r = expected_results.pop_front();
                if (exp_r.press_invalid)
                    invalid_count++;
                if (exp_r.hum_q10 == 17'd102400 || exp_r.hum_q10 == 17'd0)
                    clamp_count++;
                if (out_data !== exp_r)
                begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("Mismatch: expected %p, got %p", exp_r, out_data);
                end
            end
        end
    end

    // A long receiver hold-off, counted in cycles, lets the pipeline fill.
    always @(posedge clk)
    begin
        if (hold_off_cycles > 0)
            hold_off_cycles <= hold_off_cycles - 1;
    end

    task automatic write_reg(input logic [2:0] idx, input logic [63:0] val);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge clk); while (!cfg_ready);
        case (idx)
            ensc_pkg::RegTemp:   cal_temp = {16'd0, val[47:0]};
            ensc_pkg::RegPressA: cal_pa   = {16'd0, val[47:0]};
            ensc_pkg::RegPressB: cal_pb   = {16'd0, val[47:0]};
            ensc_pkg::RegPressC: cal_pc   = {16'd0, val[47:0]};
            ensc_pkg::RegHum:    cal_hum  = val;
            default:             ;
        endcase
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // Waits until every sample has left and the pipeline is quiet.
    task automatic drain();
        while (sample_queue.size() > 0 || in_valid || expected_results.size() > 0)
            @(posedge clk);
        repeat (PipeDepth + 4) @(posedge clk);
    endtask

    function automatic logic [63:0] rnd64();
        return {$urandom(), $urandom()};
    endfunction

    function automatic ensc_pkg::sample_t rnd_sample();
        ensc_pkg::sample_t s;
        s.raw_temp  = 20'($urandom_range(20'hFFFFF));
        s.raw_press = 20'($urandom_range(20'hFFFFF));
        s.raw_hum   = 16'($urandom_range(16'hFFFF));
        // Bias most samples toward the range a real sensor reports.
        if ($urandom_range(3) != 0)
        begin
            s.raw_temp  = 20'($urandom_range(560000, 460000));
            s.raw_press = 20'($urandom_range(450000, 250000));
            s.raw_hum   = 16'($urandom_range(40000, 20000));
        end
        return s;
    endfunction

    // Typical calibration set, so the deep arithmetic sees realistic values.
    task automatic load_typical();
        write_reg(ensc_pkg::RegTemp,   {16'd0, 16'd50, 16'd26435, 16'd27504});
        write_reg(ensc_pkg::RegPressA, {16'd0, -16'sd4107 & 16'hFFFF,
                                        -16'sd10685 & 16'hFFFF, 16'd36477});
        write_reg(ensc_pkg::RegPressB, {16'd0, -16'sd7 & 16'hFFFF, 16'd140, 16'd2855});
        write_reg(ensc_pkg::RegPressC, {16'd0, 16'd6000, -16'sd14600 & 16'hFFFF, 16'd15500});
        write_reg(ensc_pkg::RegHum,    {8'd30, 12'd50, 12'd312, 8'd0, 16'd362, 8'd75});
    endtask

    task automatic run_phase(input int n, input int unsigned sp, input int unsigned rp);
        send_idle_pct = sp;
        recv_idle_pct = rp;
        repeat (n) sample_queue.push_back(rnd_sample());
        drain();
    endtask

    initial
    begin
        ensc_pkg::sample_t s;
        rst_n = 1'b0;
        in_valid = 1'b0;
        in_data = '0;
        out_ready = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = ensc_pkg::RegTemp;
        cfg_data = '0;
        cal_temp = '0; cal_pa = '0; cal_pb = '0; cal_pc = '0; cal_hum = '0;
        send_idle_pct = 0;
        recv_idle_pct = 0;
        hold_off_cycles = 0;
        mismatch_count = 0;
        result_count = 0;
        invalid_count = 0;
        clamp_count = 0;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed: reset calibration gives a zero divisor everywhere.
        s = '0;                      sample_queue.push_back(s);
        s = '1;                      sample_queue.push_back(s);
        drain();

        // Directed: typical calibration with field extremes.
        load_typical();
        s = '0;                      sample_queue.push_back(s);
        s = '1;                      sample_queue.push_back(s);
        s = '{20'd519888, 20'd415148, 16'd30000}; sample_queue.push_back(s);
        s = '{20'd519888, 20'd0, 16'hFFFF};       sample_queue.push_back(s);
        s = '{20'hFFFFF, 20'd415148, 16'd0};      sample_queue.push_back(s);
        s = '{20'd0, 20'hFFFFF, 16'd65535};       sample_queue.push_back(s);
        drain();

        // Directed: all-ones and sign-heavy calibration, plus an unknown index.
        write_reg(ensc_pkg::RegTemp, '1);
        write_reg(ensc_pkg::RegPressA, 64'h7FFF_8000_FFFF);
        write_reg(ensc_pkg::RegPressB, 64'h8000_7FFF_8000);
        write_reg(ensc_pkg::RegPressC, 64'h7FFF_8000_7FFF);
        write_reg(ensc_pkg::RegHum, '1);
        write_reg(RegUnused, rnd64());
        for (int i = 0; i < 6; i++) sample_queue.push_back(rnd_sample());
        drain();

        // Random phases with changing calibration and idling profiles.
        load_typical();
        run_phase(150, 34, 64);
        write_reg(ensc_pkg::RegPressA, rnd64());
        write_reg(ensc_pkg::RegHum, rnd64());
        run_phase(100, 64, 34);
        load_typical();
        write_reg(ensc_pkg::RegTemp,
                  (rnd64() & 64'h0000_0000_FFFF_FFFF) | 64'h1234_0000_0000);
        run_phase(100, 64, 34);
        write_reg(ensc_pkg::RegPressB, rnd64());
        write_reg(ensc_pkg::RegPressC, rnd64());
        write_reg(ensc_pkg::RegTemp, rnd64());
        run_phase(100, 0, 0);
        write_reg(ensc_pkg::RegTemp, '0);
        write_reg(ensc_pkg::RegPressA, '0);
        run_phase(30, 0, 0);

        // Back-pressure: the receiver holds off while the sender keeps going.
        load_typical();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        repeat (150) sample_queue.push_back(rnd_sample());
        hold_off_cycles = 200;
        drain();

        $display("Covered %0d results, %0d with zero pressure divisor, %0d at humidity limits.",
                 result_count, invalid_count, clamp_count);
        if (mismatch_count == 0 && expected_results.size() == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

    initial
    begin
        #5ms;
        $display("TB_ERROR");
        $finish;
    end
endmodule
